/* src/ida_pkg.sv */
// Shared constants for the integer to decimal ASCII converter.
// No dependencies; used by the channel interfaces and the top level.
package ida_pkg;

   localparam int NUM_BITS   = 64;
   localparam int NUM_DIGITS = 20;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int CHAR_W     = 6;
   localparam int MODE_W     = 2;
   localparam int IDX_W      = 5;

   // double dabble: bits consumed per pipeline stage, and stage count
   localparam int BITS_PER_STAGE = 4;
   localparam int DD_STAGES      = NUM_BITS / BITS_PER_STAGE;

   localparam logic [MODE_W-1:0] MODE_U32 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_S32 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_U64 = 2'd2;
   localparam logic [MODE_W-1:0] MODE_S64 = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

endpackage

/* src/ida_chan_if.sv */
// Valid/ready channel interfaces for the converter's request and response sides.
// Depends on ida_pkg for field widths.
interface ida_req_if;
   logic                           valid;
   logic                           ready;
   logic [ida_pkg::NUM_BITS-1:0]   number_bits;
   logic [ida_pkg::MODE_W-1:0]     mode;

   modport source (output valid, output number_bits, output mode, input ready);
   modport sink   (input valid, input number_bits, input mode, output ready);
endinterface

interface ida_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ida_pkg::CHAR_W-1:0]     ascii_char;
   logic                           last_char;

   modport source (output valid, output ascii_char, output last_char, input ready);
   modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

/* src/integer_to_decimal_ascii.sv */
// Integer to decimal ASCII converter. Each request transfer carries a 64-bit pattern and a
// mode (unsigned/signed, 32/64 bit); the block returns the decimal text, one character per
// response transfer, with last_char set on the final one. A request enters an 18-stage
// pipeline (sign/magnitude, sixteen double-dabble stages of four bits each, digit count).
// With an empty pipeline, a request passes through every stage register and then loads the
// serializer, whose busy flag drives response valid. The output serializer emits one
// character per cycle while the response side is ready, and a number's text is 1 to 20
// characters long. That serializer sets the sustained rate; requests keep flowing into the
// pipeline while earlier text is being sent.
// Depends on ida_pkg and the channel interfaces in ida_chan_if.sv.
module integer_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   ida_req_if.sink    req_chan,
   ida_rsp_if.source  rsp_chan
);

   localparam int NB   = ida_pkg::NUM_BITS;
   localparam int BW   = ida_pkg::BCD_W;
   localparam int NS   = ida_pkg::DD_STAGES;
   localparam int LAST = NS + 1;           // digit count stage

   function automatic logic [BW+NB-1:0] dd_step(input logic [BW+NB-1:0] v);
      logic [BW+NB-1:0] r;
      r = v;
      for (int d = 0; d < ida_pkg::NUM_DIGITS; d++) begin
         if (r[NB + d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] >= 4'd5) begin
            r[NB + d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] =
               r[NB + d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] + 4'd3;
         end
      end
      return r << 1;
   endfunction

   logic [LAST:0]    vld_ff;
   logic [LAST:0]    vld_prev;
   logic [LAST+1:0]  rdy;
   logic             neg_ff [0:LAST];
   logic [NB-1:0]    bin_ff [0:NS-1];
   logic [BW-1:0]    bcd_ff [1:LAST];
   logic [ida_pkg::IDX_W-1:0] top_ff;

   logic             neg_in;
   logic [NB-1:0]    mag_in;
   logic [ida_pkg::IDX_W-1:0] top_in;

   // serializer
   logic             busy_ff;
   logic             neg_pend_ff;
   logic [ida_pkg::IDX_W-1:0] idx_ff;
   logic [BW-1:0]    ser_bcd_ff;
   logic             ser_take;
   logic             ser_last;
   logic             ser_free;
   logic             ser_load;
   logic [ida_pkg::DIGIT_W-1:0] cur_digit;

   // ---- pipeline flow control ----
   assign vld_prev = {vld_ff[LAST-1:0], req_chan.valid};
   assign rdy[LAST+1] = ser_free;
   genvar g;
   generate
      for (g = 0; g <= LAST; g++) begin : g_rdy
         assign rdy[g] = !vld_ff[g] || rdy[g+1];
      end
   endgenerate
   assign req_chan.ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i <= LAST; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_prev[i];
            end
         end
      end
   end

   // ---- stage 0: sign and magnitude ----
   always_comb begin
      neg_in = 1'b0;
      mag_in = req_chan.number_bits;
      unique case (req_chan.mode)
         ida_pkg::MODE_U32: mag_in = {32'd0, req_chan.number_bits[31:0]};
         ida_pkg::MODE_S32: begin
            neg_in = req_chan.number_bits[31];
            mag_in = neg_in ? {32'd0, (~req_chan.number_bits[31:0]) + 32'd1}
                            : {32'd0, req_chan.number_bits[31:0]};
         end
         ida_pkg::MODE_U64: mag_in = req_chan.number_bits;
         ida_pkg::MODE_S64: begin
            neg_in = req_chan.number_bits[NB-1];
            mag_in = neg_in ? (~req_chan.number_bits) + 64'd1 : req_chan.number_bits;
         end
         default: mag_in = req_chan.number_bits;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         neg_ff[0] <= neg_in;
         bin_ff[0] <= mag_in;
      end
   end

   // ---- stages 1..NS: double dabble, four bits per stage ----
   generate
      for (g = 1; g <= NS; g++) begin : g_dd
         logic [BW+NB-1:0] acc_in;
         logic [BW-1:0]    prev_bcd;
         if (g == 1) begin : g_first
            assign prev_bcd = '0;
         end else begin : g_rest
            assign prev_bcd = bcd_ff[g-1];
         end
         always_comb begin
            acc_in = {prev_bcd, bin_ff[g-1]};
            for (int s = 0; s < ida_pkg::BITS_PER_STAGE; s++) begin
               acc_in = dd_step(acc_in);
            end
         end
         always_ff @(posedge clock) begin
            if (rdy[g]) begin
               neg_ff[g] <= neg_ff[g-1];
               bcd_ff[g] <= acc_in[BW+NB-1:NB];
            end
         end
         // binary bits are all shifted out after the last stage
         if (g < NS) begin : g_bin
            always_ff @(posedge clock) begin
               if (rdy[g]) begin
                  bin_ff[g] <= acc_in[NB-1:0];
               end
            end
         end
      end
   endgenerate

   // ---- final stage: index of the leading nonzero digit ----
   always_comb begin
      top_in = '0;
      for (int d = 1; d < ida_pkg::NUM_DIGITS; d++) begin
         if (bcd_ff[NS][d*ida_pkg::DIGIT_W +: ida_pkg::DIGIT_W] != 4'd0) begin
            top_in = ida_pkg::IDX_W'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[LAST]) begin
         neg_ff[LAST] <= neg_ff[NS];
         bcd_ff[LAST] <= bcd_ff[NS];
         top_ff       <= top_in;
      end
   end

   // ---- output serializer ----
   assign ser_take  = busy_ff && rsp_chan.ready;
   assign ser_last  = !neg_pend_ff && (idx_ff == '0);
   assign ser_free  = !busy_ff || (ser_take && ser_last);
   assign ser_load  = vld_ff[LAST] && ser_free;
   assign cur_digit = ser_bcd_ff[{idx_ff, 2'b00} +: ida_pkg::DIGIT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         neg_pend_ff <= 1'b0;
      end else if (ser_load) begin
         busy_ff     <= 1'b1;
         neg_pend_ff <= neg_ff[LAST];
      end else if (ser_take) begin
         if (ser_last) begin
            busy_ff <= 1'b0;
         end
         neg_pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         idx_ff     <= top_ff;
         ser_bcd_ff <= bcd_ff[LAST];
      end else if (ser_take && !neg_pend_ff && !ser_last) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   assign rsp_chan.valid      = busy_ff;
   assign rsp_chan.ascii_char = neg_pend_ff ? ida_pkg::CHAR_MINUS
                                            : ida_pkg::CHAR_ZERO + {2'b00, cur_digit};
   assign rsp_chan.last_char  = ser_last;

   // ---- assertions ----
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.ascii_char == ida_pkg::CHAR_MINUS) ||
                         (rsp_chan.ascii_char >= ida_pkg::CHAR_ZERO &&
                          rsp_chan.ascii_char <= ida_pkg::CHAR_NINE))
      else $error("response character outside '-' and digits");

   a_lead_digit: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST] && top_ff != '0) |->
         (bcd_ff[LAST][{top_ff, 2'b00} +: ida_pkg::DIGIT_W] != 4'd0))
      else $error("leading digit index points at a zero digit");

   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      neg_pend_ff |-> busy_ff && !rsp_chan.last_char)
      else $error("minus pending outside an active number");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy_ff && (vld_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

/* test/ida_text_checker.sv */
// Checker for the integer to decimal ASCII converter: predicts the character stream of each
// request transfer and compares every response transfer against it, in order.
// Depends on ida_pkg and the channel interfaces in ida_chan_if.sv.
module ida_text_checker
   import ida_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   ida_req_if     req_mon,
   ida_rsp_if     rsp_mon,
   output int     error_count,
   output int     pending_count
);

   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last_char;
   } text_char_type;

   text_char_type char_q[$];

   // Queue the decimal text of one number, sign first, most significant digit first.
   task automatic queue_number_text(input logic [NUM_BITS-1:0] bits,
                                    input logic [MODE_W-1:0] mode);
      logic [NUM_BITS-1:0] magnitude;
      logic                is_negative;
      logic                wide_mode;
      logic                signed_mode;
      logic [DIGIT_W-1:0]  digit_buf[NUM_DIGITS];
      int                  num_digits;
      text_char_type       entry;
      wide_mode   = (mode == MODE_U64) || (mode == MODE_S64);
      signed_mode = (mode == MODE_S32) || (mode == MODE_S64);
      if (wide_mode) begin
         is_negative = signed_mode && bits[63];
         magnitude   = is_negative ? (~bits + 64'd1) : bits;
      end else begin
         is_negative = signed_mode && bits[31];
         magnitude   = {32'd0, is_negative ? (~bits[31:0] + 32'd1) : bits[31:0]};
      end
      num_digits = 0;
      do begin
         digit_buf[num_digits] = DIGIT_W'(magnitude % 64'd10);
         num_digits++;
         magnitude = magnitude / 64'd10;
      end while (magnitude != 0);
      if (is_negative) begin
         entry.ascii_char = CHAR_MINUS;
         entry.last_char  = 1'b0;
         char_q = {char_q, entry};
      end
      for (int k = num_digits - 1; k >= 0; k--) begin
         entry.ascii_char = CHAR_ZERO + CHAR_W'(digit_buf[k]);
         entry.last_char  = (k == 0);
         char_q = {char_q, entry};
      end
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            queue_number_text(req_mon.number_bits, req_mon.mode);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (char_q.size() == 0) begin
               $display("%0t: unexpected character transfer: char %0d last %0b",
                        $time, rsp_mon.ascii_char, rsp_mon.last_char);
               error_count++;
            end else begin
               want = char_q.pop_front();
               if (rsp_mon.ascii_char !== want.ascii_char) begin
                  $display("%0t: ascii_char mismatch: expected %0d actual %0d",
                           $time, want.ascii_char, rsp_mon.ascii_char);
                  error_count++;
               end
               if (rsp_mon.last_char !== want.last_char) begin
                  $display("%0t: last_char mismatch: expected %0b actual %0b",
                           $time, want.last_char, rsp_mon.last_char);
                  error_count++;
               end
            end
         end
      end
      pending_count <= char_q.size();
   end

endmodule

/* test/tb.sv */
// Top of the converter testbench: clock, reset, request stimulus and response stalls.
// Depends on ida_pkg, ida_chan_if.sv, the converter RTL and ida_text_checker.sv.
module tb;
   import ida_pkg::*;

   typedef enum int {RDY_ALWAYS, RDY_LIGHT_STALL, RDY_HEAVY_STALL, RDY_PERIODIC} rdy_style_type;

   localparam int RANDOM_NUMBERS = 430;
   localparam int DRAIN_CYCLES   = 40;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;

   ida_req_if req_chan ();
   ida_rsp_if rsp_chan ();

   integer_to_decimal_ascii i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ida_text_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [63:0] pow10(input int k);
      logic [63:0] val;
      val = 64'd1;
      for (int i = 0; i < k; i++) val = val * 64'd10;
      return val;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Operand mix: full-width noise, digit-length control, power-of-ten boundaries,
   // small negatives and the signed/unsigned extremes.
   function automatic logic [63:0] pick_number();
      logic [63:0] val;
      logic [31:0] low_word;
      case ($urandom_range(0, 7))
         0, 1: val = rand_word();
         2: val = rand_word() % pow10($urandom_range(1, 19));
         3: val = pow10($urandom_range(0, 19)) - 64'd1 + 64'($urandom_range(0, 2));
         4: val = ~64'($urandom_range(0, 100000)) + 64'd1;
         5: begin
            case ($urandom_range(0, 4))
               0: low_word = 32'h0000_0000;
               1: low_word = 32'h8000_0000;
               2: low_word = 32'h7FFF_FFFF;
               3: low_word = 32'hFFFF_FFFF;
               default: low_word = ~32'($urandom_range(0, 999)) + 32'd1;
            endcase
            val = {$urandom, low_word};
         end
         6: begin
            case ($urandom_range(0, 4))
               0: val = 64'd0;
               1: val = 64'd1;
               2: val = 64'hFFFF_FFFF_FFFF_FFFF;
               3: val = 64'h8000_0000_0000_0000;
               default: val = 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
         end
         default: val = 64'($urandom_range(0, 999));
      endcase
      return val;
   endfunction

   // Called at a rising edge; returns at the edge where the transfer happens.
   task automatic send_number(input logic [63:0] bits, input logic [MODE_W-1:0] mode);
      req_chan.valid       <= 1'b1;
      req_chan.number_bits <= bits;
      req_chan.mode        <= mode;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_count != 0);
   endtask

   // response side stalls
   initial begin
      rdy_style_type stall_style;
      int            style_left;
      logic [2:0]    phase_cnt;
      rsp_chan.ready = 1'b0;
      stall_style    = RDY_ALWAYS;
      style_left     = 0;
      phase_cnt      = 3'd0;
      forever begin
         @(posedge clock);
         if (style_left == 0) begin
            stall_style = rdy_style_type'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 120);
         end
         style_left--;
         phase_cnt++;
         case (stall_style)
            RDY_ALWAYS:      rsp_chan.ready <= 1'b1;
            RDY_LIGHT_STALL: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            RDY_HEAVY_STALL: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
            default:         rsp_chan.ready <= (phase_cnt < 3'd5);
         endcase
      end
   end

   initial begin
      int burst_len;
      int gap_len;
      int sent;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.number_bits = '0;
      req_chan.mode        = MODE_U32;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero in every mode, then the width extremes and the digit-count boundaries
      send_number(64'd0, MODE_U32);
      send_number(64'd0, MODE_S32);
      send_number(64'd0, MODE_U64);
      send_number(64'd0, MODE_S64);
      send_number(64'hFFFF_FFFF, MODE_U32);
      send_number(64'hFFFF_FFFF, MODE_S32);
      send_number(64'h8000_0000, MODE_S32);
      send_number(64'h7FFF_FFFF, MODE_S32);
      send_number(64'hDEAD_BEEF_0000_0000, MODE_U32);
      send_number(64'hFFFF_FFFF_8000_0000, MODE_S32);
      send_number(64'h0000_0001_0000_0000, MODE_U64);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_U64);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_S64);
      send_number(64'h8000_0000_0000_0000, MODE_S64);
      send_number(64'h7FFF_FFFF_FFFF_FFFF, MODE_S64);
      send_number(pow10(19) - 64'd1, MODE_U64);
      send_number(pow10(19), MODE_U64);
      send_number(64'd1, MODE_U32);
      send_number(64'd9, MODE_U64);
      send_number(64'd10, MODE_S64);
      send_number(64'd9999, MODE_U32);
      send_number(64'd10000, MODE_S32);
      send_number(64'd99999999, MODE_U64);
      send_number(64'd100000000, MODE_U32);
      send_number(pow10(16) - 64'd1, MODE_S64);
      send_number(pow10(16), MODE_U64);

      req_chan.valid <= 1'b0;
      wait_drained();

      sent = 0;
      while (sent < RANDOM_NUMBERS) begin
         burst_len = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
         for (int i = 0; i < burst_len && sent < RANDOM_NUMBERS; i++) begin
            send_number(pick_number(), MODE_W'($urandom_range(0, 3)));
            sent++;
            if (sent == RANDOM_NUMBERS / 2) begin
               // hold off until the pipeline and serializer are empty
               req_chan.valid <= 1'b0;
               wait_drained();
            end
         end
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap_len > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
